>>> rtl/qfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfn_pkg
// Shared types, constants and arithmetic steps for the quad frame pipeline.
// ----------------------------------------------------------------------------
package qfn_pkg;

    // Normal fraction bits (Q1.14)
    localparam int FRAC = 14;
    // |nz| at or above this selects the x reference axis (|nz|*100 > 99*2^F)
    localparam int AXIS_MIN = (99 * (1 << FRAC)) / 100 + 1;
    // Squared right length at or above this gets normalized (S*1e6 > 2^(2F))
    localparam longint NORM_MIN = ((64'sd1 <<< (2 * FRAC)) / 1000000) + 1;
    // Output clamp
    localparam int OUT_LIMIT = 65535;
    // Unit vector scale: r * 2^(F+8) / L
    localparam int UNIT_SHIFT = FRAC + 8;

    // Square root: radicand is S * 2^16
    localparam int RAD_W     = 48;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

    // Divider: 16 quotient bits
    localparam int QUO_W      = 16;
    localparam int NUM_W      = 18 + UNIT_SHIFT - 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // Item payload that travels the whole pipeline
    typedef struct packed {
        logic signed [19:0] ox;
        logic signed [19:0] oy;
        logic signed [19:0] oz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        w;
        logic [15:0]        h;
        logic               xax;   // x reference axis in use
        logic signed [17:0] ra;    // first non-zero right component
        logic signed [17:0] rb;    // second non-zero right component
        logic               norm;  // right gets normalized
    } carry_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
    } div_state_t;

    // One digit of the integer square root
    function automatic sq_state_t sqrt_step(sq_state_t s);
        sq_state_t  o;
        logic [REM_W+1:0] r2;
        logic [REM_W+1:0] trial;
        o     = s;
        r2    = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        if (r2 >= trial)
        begin
            o.rem  = REM_W'(r2 - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = REM_W'(r2);
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.rad = s.rad << 2;
        return o;
    endfunction

    // One bit of restoring division
    function automatic div_state_t div_step(div_state_t s, logic [ROOT_W-1:0] den);
        div_state_t o;
        logic [ROOT_W:0] r2;
        o  = s;
        r2 = {s.rem, s.low[QUO_W-1]};
        if (r2 >= {1'b0, den})
        begin
            o.rem = ROOT_W'(r2 - {1'b0, den});
            o.quo = {s.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[ROOT_W-1:0];
            o.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        o.low = s.low << 1;
        return o;
    endfunction

    // Round half up at bit s, then clamp to the output range
    function automatic logic signed [16:0] sat_round(logic signed [51:0] v, int s);
        logic signed [51:0] t;
        t = (v + (52'sd1 <<< (s - 1))) >>> s;
        if (t > 52'(OUT_LIMIT))
            return 17'(OUT_LIMIT);
        else if (t < -52'(OUT_LIMIT))
            return -17'(OUT_LIMIT);
        else
            return t[16:0];
    endfunction

endpackage

>>> rtl/quad_frame_from_normal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_frame_from_normal_core
// Quad placement transform (right*width, up*height, normal, origin) from a
// facing normal, built as a stall-aware pipeline.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless in_stall is high, and each
// request passes through 3 setup stages (axis choice, squares, length test),
// 12 square root stages (two root bits each of the 24-bit length), 9 divider
// stages (numerator setup, then two quotient bits each of 16), and 5 stages
// for the cross product, size scaling and clamping. Every stage holds its own
// valid bit, so empty stages fill even while the result register is stalled.
module quad_frame_from_normal_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [19:0] origin_x,
    input  logic signed [19:0] origin_y,
    input  logic signed [19:0] origin_z,
    input  logic signed [15:0] facing_x,
    input  logic signed [15:0] facing_y,
    input  logic signed [15:0] facing_z,
    input  logic [15:0]        quad_width,
    input  logic [15:0]        quad_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] right_scaled_x,
    output logic signed [16:0] right_scaled_y,
    output logic signed [16:0] right_scaled_z,
    output logic signed [16:0] up_scaled_x,
    output logic signed [16:0] up_scaled_y,
    output logic signed [16:0] up_scaled_z,
    output logic signed [15:0] normal_col_x,
    output logic signed [15:0] normal_col_y,
    output logic signed [15:0] normal_col_z,
    output logic signed [19:0] translate_x,
    output logic signed [19:0] translate_y,
    output logic signed [19:0] translate_z
);

    logic                         su_valid, su_stall;
    qfn_pkg::carry_t              su_carry;
    logic [qfn_pkg::RAD_W-1:0]    su_rad;
    logic                         sq_valid, sq_stall;
    qfn_pkg::carry_t              sq_carry;
    logic [qfn_pkg::ROOT_W-1:0]   sq_root;
    logic                         dv_valid, dv_stall;
    qfn_pkg::carry_t              dv_carry;
    logic [qfn_pkg::QUO_W-1:0]    dv_qa, dv_qb;

    qfn_setup u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .facing_x    (facing_x),
        .facing_y    (facing_y),
        .facing_z    (facing_z),
        .quad_width  (quad_width),
        .quad_height (quad_height),
        .out_valid   (su_valid),
        .out_stall   (su_stall),
        .out_carry   (su_carry),
        .out_rad     (su_rad)
    );

    qfn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .in_stall  (su_stall),
        .in_carry  (su_carry),
        .in_rad    (su_rad),
        .out_valid (sq_valid),
        .out_stall (sq_stall),
        .out_carry (sq_carry),
        .out_root  (sq_root)
    );

    qfn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_stall  (sq_stall),
        .in_carry  (sq_carry),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_stall (dv_stall),
        .out_carry (dv_carry),
        .out_qa    (dv_qa),
        .out_qb    (dv_qb)
    );

    qfn_frame u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (dv_valid),
        .in_stall       (dv_stall),
        .in_carry       (dv_carry),
        .in_qa          (dv_qa),
        .in_qb          (dv_qb),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .right_scaled_x (right_scaled_x),
        .right_scaled_y (right_scaled_y),
        .right_scaled_z (right_scaled_z),
        .up_scaled_x    (up_scaled_x),
        .up_scaled_y    (up_scaled_y),
        .up_scaled_z    (up_scaled_z),
        .normal_col_x   (normal_col_x),
        .normal_col_y   (normal_col_y),
        .normal_col_z   (normal_col_z),
        .translate_x    (translate_x),
        .translate_y    (translate_y),
        .translate_z    (translate_z)
    );

endmodule

>>> rtl/qfn_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfn_setup
// Picks the reference axis, forms the raw right axis and its squared length.
// ----------------------------------------------------------------------------
module qfn_setup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [19:0]            origin_x,
    input  logic signed [19:0]            origin_y,
    input  logic signed [19:0]            origin_z,
    input  logic signed [15:0]            facing_x,
    input  logic signed [15:0]            facing_y,
    input  logic signed [15:0]            facing_z,
    input  logic [15:0]                   quad_width,
    input  logic [15:0]                   quad_height,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qfn_pkg::carry_t               out_carry,
    output logic [qfn_pkg::RAD_W-1:0]     out_rad
);

    logic [2:0]             vld_reg;
    logic [3:0]             go;
    qfn_pkg::carry_t        c1_reg, c1_next;
    qfn_pkg::carry_t        c2_reg;
    qfn_pkg::carry_t        c3_reg, c3_next;
    logic [31:0]            sqa_reg, sqa_next;
    logic [31:0]            sqb_reg, sqb_next;
    logic [qfn_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic signed [16:0]     nz_ext;
    logic [16:0]            anz;
    logic signed [35:0]     pa;
    logic signed [35:0]     pb;
    logic [32:0]            sum;

    // Stage advance chain
    always_comb
    begin
        go[3] = !out_stall;
        go[2] = !vld_reg[2] || go[3];
        go[1] = !vld_reg[1] || go[2];
        go[0] = !vld_reg[0] || go[1];
    end

    assign in_stall = !go[0];

    // Stage 1: axis choice and raw right axis
    always_comb
    begin
        nz_ext      = 17'(facing_z);
        anz         = nz_ext[16] ? 17'(-nz_ext) : 17'(nz_ext);
        c1_next.ox  = origin_x;
        c1_next.oy  = origin_y;
        c1_next.oz  = origin_z;
        c1_next.nx  = facing_x;
        c1_next.ny  = facing_y;
        c1_next.nz  = facing_z;
        c1_next.w   = quad_width;
        c1_next.h   = quad_height;
        c1_next.xax = (anz >= 17'(qfn_pkg::AXIS_MIN));
        c1_next.ra  = c1_next.xax ? -18'(facing_z) : -18'(facing_y);
        c1_next.rb  = c1_next.xax ? 18'(facing_y) : 18'(facing_x);
        c1_next.norm = 1'b0;
    end

    // Stage 2: squares
    always_comb
    begin
        pa       = c1_reg.ra * c1_reg.ra;
        pb       = c1_reg.rb * c1_reg.rb;
        sqa_next = pa[31:0];
        sqb_next = pb[31:0];
    end

    // Stage 3: length test and radicand
    always_comb
    begin
        sum          = {1'b0, sqa_reg} + {1'b0, sqb_reg};
        c3_next      = c2_reg;
        c3_next.norm = (64'(sum) >= 64'(qfn_pkg::NORM_MIN));
        rad_next     = {sum[31:0], 16'h0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (go[0]) vld_reg[0] <= in_valid;
            if (go[1]) vld_reg[1] <= vld_reg[0];
            if (go[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            c1_reg <= c1_next;
        end
        if (go[1])
        begin
            c2_reg  <= c1_reg;
            sqa_reg <= sqa_next;
            sqb_reg <= sqb_next;
        end
        if (go[2])
        begin
            c3_reg  <= c3_next;
            rad_reg <= rad_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_carry = c3_reg;
    assign out_rad   = rad_reg;

endmodule

>>> rtl/qfn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfn_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module qfn_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qfn_pkg::carry_t               in_carry,
    input  logic [qfn_pkg::RAD_W-1:0]     in_rad,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qfn_pkg::carry_t               out_carry,
    output logic [qfn_pkg::ROOT_W-1:0]    out_root
);

    localparam int NS = qfn_pkg::SQ_STAGES;

    logic [NS-1:0]        vld_reg;
    logic [NS:0]          go;
    qfn_pkg::carry_t      c_reg [NS];
    qfn_pkg::sq_state_t   s_reg [NS];
    qfn_pkg::sq_state_t   s_next [NS];

    // Stage advance chain
    always_comb
    begin
        go[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
            go[k] = !vld_reg[k] || go[k+1];
    end

    assign in_stall = !go[0];

    // Digit steps per stage
    always_comb
    begin
        qfn_pkg::sq_state_t tmp;
        tmp.rad  = in_rad;
        tmp.rem  = '0;
        tmp.root = '0;
        for (int j = 0; j < qfn_pkg::SQ_STEPS; j++)
            tmp = qfn_pkg::sqrt_step(tmp);
        s_next[0] = tmp;
        for (int k = 1; k < NS; k++)
        begin
            tmp = s_reg[k-1];
            for (int j = 0; j < qfn_pkg::SQ_STEPS; j++)
                tmp = qfn_pkg::sqrt_step(tmp);
            s_next[k] = tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (go[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (go[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            c_reg[0] <= in_carry;
            s_reg[0] <= s_next[0];
        end
        for (int k = 1; k < NS; k++)
        begin
            if (go[k])
            begin
                c_reg[k] <= c_reg[k-1];
                s_reg[k] <= s_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_carry = c_reg[NS-1];
    assign out_root  = s_reg[NS-1].root;

endmodule

>>> rtl/qfn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfn_div
// Two-lane pipelined divider: |r| * 2^(F+8) / L, rounded, two bits per stage.
// ----------------------------------------------------------------------------
module qfn_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qfn_pkg::carry_t               in_carry,
    input  logic [qfn_pkg::ROOT_W-1:0]    in_root,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qfn_pkg::carry_t               out_carry,
    output logic [qfn_pkg::QUO_W-1:0]     out_qa,
    output logic [qfn_pkg::QUO_W-1:0]     out_qb
);

    localparam int NS = qfn_pkg::DIV_STAGES + 1;

    logic [NS-1:0]             vld_reg;
    logic [NS:0]               go;
    qfn_pkg::carry_t           c_reg [NS];
    logic [qfn_pkg::ROOT_W-1:0] den_reg [NS];
    qfn_pkg::div_state_t       a_reg [NS];
    qfn_pkg::div_state_t       b_reg [NS];
    qfn_pkg::div_state_t       a_next [NS];
    qfn_pkg::div_state_t       b_next [NS];
    logic [17:0]               mag_a, mag_b;
    logic [qfn_pkg::NUM_W-1:0] num_a, num_b;

    // Stage advance chain
    always_comb
    begin
        go[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
            go[k] = !vld_reg[k] || go[k+1];
    end

    assign in_stall = !go[0];

    // Setup stage (rounded numerators), then quotient steps
    always_comb
    begin
        qfn_pkg::div_state_t ta, tb;
        mag_a = in_carry.ra[17] ? 18'(-in_carry.ra) : 18'(in_carry.ra);
        mag_b = in_carry.rb[17] ? 18'(-in_carry.rb) : 18'(in_carry.rb);
        num_a = (qfn_pkg::NUM_W'(mag_a) << qfn_pkg::UNIT_SHIFT)
              + qfn_pkg::NUM_W'(in_root >> 1);
        num_b = (qfn_pkg::NUM_W'(mag_b) << qfn_pkg::UNIT_SHIFT)
              + qfn_pkg::NUM_W'(in_root >> 1);
        a_next[0].rem = qfn_pkg::ROOT_W'(num_a >> qfn_pkg::QUO_W);
        a_next[0].low = num_a[qfn_pkg::QUO_W-1:0];
        a_next[0].quo = '0;
        b_next[0].rem = qfn_pkg::ROOT_W'(num_b >> qfn_pkg::QUO_W);
        b_next[0].low = num_b[qfn_pkg::QUO_W-1:0];
        b_next[0].quo = '0;
        for (int k = 1; k < NS; k++)
        begin
            ta = a_reg[k-1];
            tb = b_reg[k-1];
            for (int j = 0; j < qfn_pkg::DIV_STEPS; j++)
            begin
                ta = qfn_pkg::div_step(ta, den_reg[k-1]);
                tb = qfn_pkg::div_step(tb, den_reg[k-1]);
            end
            a_next[k] = ta;
            b_next[k] = tb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (go[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (go[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            c_reg[0]   <= in_carry;
            den_reg[0] <= in_root;
            a_reg[0]   <= a_next[0];
            b_reg[0]   <= b_next[0];
        end
        for (int k = 1; k < NS; k++)
        begin
            if (go[k])
            begin
                c_reg[k]   <= c_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                a_reg[k]   <= a_next[k];
                b_reg[k]   <= b_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_carry = c_reg[NS-1];
    assign out_qa    = a_reg[NS-1].quo;
    assign out_qb    = b_reg[NS-1].quo;

endmodule

>>> rtl/qfn_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfn_frame
// Final right axis, up = n x right, scaling by size, rounding and clamping.
// ----------------------------------------------------------------------------
module qfn_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qfn_pkg::carry_t               in_carry,
    input  logic [qfn_pkg::QUO_W-1:0]     in_qa,
    input  logic [qfn_pkg::QUO_W-1:0]     in_qb,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [16:0]            right_scaled_x,
    output logic signed [16:0]            right_scaled_y,
    output logic signed [16:0]            right_scaled_z,
    output logic signed [16:0]            up_scaled_x,
    output logic signed [16:0]            up_scaled_y,
    output logic signed [16:0]            up_scaled_z,
    output logic signed [15:0]            normal_col_x,
    output logic signed [15:0]            normal_col_y,
    output logic signed [15:0]            normal_col_z,
    output logic signed [19:0]            translate_x,
    output logic signed [19:0]            translate_y,
    output logic signed [19:0]            translate_z
);

    logic [4:0]          vld_reg;
    logic [5:0]          go;
    qfn_pkg::carry_t     c1_reg, c1_next;
    qfn_pkg::carry_t     c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [17:0]  qa_s, qb_s;
    logic signed [33:0]  nxa_reg, nxb_reg, nya_reg, nyb_reg, nza_reg, nzb_reg;
    logic signed [34:0]  rwa_reg, rwb_reg;
    logic signed [34:0]  u0_reg, u1_reg, u2_reg;
    logic signed [34:0]  u0_next, u1_next, u2_next;
    logic signed [16:0]  rx3_reg, ry3_reg, rz3_reg;
    logic signed [16:0]  rx4_reg, ry4_reg, rz4_reg;
    logic signed [16:0]  rx5_reg, ry5_reg, rz5_reg;
    logic signed [51:0]  uh0_reg, uh1_reg, uh2_reg;
    logic signed [16:0]  ux5_reg, uy5_reg, uz5_reg;
    logic signed [16:0]  h_s;
    logic signed [16:0]  w_s;

    // Stage advance chain
    always_comb
    begin
        go[5] = !out_stall;
        go[4] = !vld_reg[4] || go[5];
        go[3] = !vld_reg[3] || go[4];
        go[2] = !vld_reg[2] || go[3];
        go[1] = !vld_reg[1] || go[2];
        go[0] = !vld_reg[0] || go[1];
    end

    assign in_stall = !go[0];

    // Stage 1: signed unit components or raw right axis
    always_comb
    begin
        qa_s    = 18'(in_qa);
        qb_s    = 18'(in_qb);
        c1_next = in_carry;
        if (in_carry.norm)
        begin
            c1_next.ra = in_carry.ra[17] ? -qa_s : qa_s;
            c1_next.rb = in_carry.rb[17] ? -qb_s : qb_s;
        end
    end

    // Stage 3: cross product sums and scaled right axis
    always_comb
    begin
        if (c2_reg.xax)
        begin
            u0_next = 35'(nyb_reg) - 35'(nza_reg);
            u1_next = -35'(nxb_reg);
            u2_next = 35'(nxa_reg);
        end
        else
        begin
            u0_next = -35'(nzb_reg);
            u1_next = 35'(nza_reg);
            u2_next = 35'(nxb_reg) - 35'(nya_reg);
        end
    end

    assign w_s = $signed({1'b0, c1_reg.w});
    assign h_s = $signed({1'b0, c3_reg.h});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (go[0]) vld_reg[0] <= in_valid;
            if (go[1]) vld_reg[1] <= vld_reg[0];
            if (go[2]) vld_reg[2] <= vld_reg[1];
            if (go[3]) vld_reg[3] <= vld_reg[2];
            if (go[4]) vld_reg[4] <= vld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            c1_reg <= c1_next;
        end
        // Stage 2: products
        if (go[1])
        begin
            c2_reg  <= c1_reg;
            nxa_reg <= c1_reg.nx * c1_reg.ra;
            nxb_reg <= c1_reg.nx * c1_reg.rb;
            nya_reg <= c1_reg.ny * c1_reg.ra;
            nyb_reg <= c1_reg.ny * c1_reg.rb;
            nza_reg <= c1_reg.nz * c1_reg.ra;
            nzb_reg <= c1_reg.nz * c1_reg.rb;
            rwa_reg <= c1_reg.ra * w_s;
            rwb_reg <= c1_reg.rb * w_s;
        end
        if (go[2])
        begin
            c3_reg  <= c2_reg;
            u0_reg  <= u0_next;
            u1_reg  <= u1_next;
            u2_reg  <= u2_next;
            rx3_reg <= c2_reg.xax ? 17'sd0
                     : qfn_pkg::sat_round(52'(rwa_reg), qfn_pkg::FRAC);
            ry3_reg <= qfn_pkg::sat_round(52'(c2_reg.xax ? rwa_reg : rwb_reg), qfn_pkg::FRAC);
            rz3_reg <= c2_reg.xax ? qfn_pkg::sat_round(52'(rwb_reg), qfn_pkg::FRAC)
                     : 17'sd0;
        end
        // Stage 4: up times height
        if (go[3])
        begin
            c4_reg  <= c3_reg;
            uh0_reg <= u0_reg * h_s;
            uh1_reg <= u1_reg * h_s;
            uh2_reg <= u2_reg * h_s;
            rx4_reg <= rx3_reg;
            ry4_reg <= ry3_reg;
            rz4_reg <= rz3_reg;
        end
        // Stage 5: output register
        if (go[4])
        begin
            c5_reg  <= c4_reg;
            ux5_reg <= qfn_pkg::sat_round(uh0_reg, 2 * qfn_pkg::FRAC);
            uy5_reg <= qfn_pkg::sat_round(uh1_reg, 2 * qfn_pkg::FRAC);
            uz5_reg <= qfn_pkg::sat_round(uh2_reg, 2 * qfn_pkg::FRAC);
            rx5_reg <= rx4_reg;
            ry5_reg <= ry4_reg;
            rz5_reg <= rz4_reg;
        end
    end

    assign out_valid      = vld_reg[4];
    assign right_scaled_x = rx5_reg;
    assign right_scaled_y = ry5_reg;
    assign right_scaled_z = rz5_reg;
    assign up_scaled_x    = ux5_reg;
    assign up_scaled_y    = uy5_reg;
    assign up_scaled_z    = uz5_reg;
    assign normal_col_x   = c5_reg.nx;
    assign normal_col_y   = c5_reg.ny;
    assign normal_col_z   = c5_reg.nz;
    assign translate_x    = c5_reg.ox;
    assign translate_y    = c5_reg.oy;
    assign translate_z    = c5_reg.oz;

    // Right axis is zero on the component that the chosen reference axis kills
    a_xax_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && c3_reg.xax) |-> (rx3_reg == 17'sd0))
        else $error("right x not zero on x reference axis");

    a_up_rz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !c3_reg.xax) |-> (rz3_reg == 17'sd0))
        else $error("right z not zero on world up axis");

    // Normalized components stay within +/-16400 (just above one in Q1.14)
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && c1_reg.norm) |->
            (c1_reg.ra <= 18'sd16400 && c1_reg.ra >= -18'sd16400 &&
             c1_reg.rb <= 18'sd16400 && c1_reg.rb >= -18'sd16400))
        else $error("normalized right axis out of range");

endmodule
